@@ rtl/csau_pkg.sv @@
// Shared types, widths and codes for the checked signed arithmetic unit.
`default_nettype none
package csau_pkg;
    localparam int DataWidth = 32;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_DIV = 2'd2,
        FUNC_MUL = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    // Item travelling down the cell chain.
    typedef struct packed {
        logic                  vld;
        func_t                 func;
        logic                  neg;
        logic [DataWidth-1:0]  amag;
        logic [DataWidth-1:0]  bmag;
        logic [DataWidth-1:0]  quo;
        logic [DataWidth-1:0]  rem;
        logic [2*DataWidth-1:0] prod;
        logic [DataWidth-1:0]  fast_val;
        status_t               fast_st;
    } cell_t;
endpackage
`default_nettype wire

@@ rtl/csau_cell.sv @@
// One cell of the chain: one restoring division bit and one shift-add multiply bit.
`default_nettype none
module csau_cell
    import csau_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  cell_t      cin,
    output cell_t      cout
);
    cell_t                  c_next;
    logic [DataWidth:0]     trial;
    logic [DataWidth-1:0]   rem_sh;
    logic                   abit;

    always_comb
    begin
        c_next = cin;
        abit   = cin.amag[DataWidth-1];
        // Dividend bits enter the remainder from the top of amag; quo gathers results.
        rem_sh = {cin.rem[DataWidth-2:0], abit};
        trial  = {cin.rem, abit} - {1'b0, cin.bmag};
        if (!trial[DataWidth])
        begin
            c_next.rem = trial[DataWidth-1:0];
            c_next.quo = {cin.quo[DataWidth-2:0], 1'b1};
        end
        else
        begin
            c_next.rem = rem_sh;
            c_next.quo = {cin.quo[DataWidth-2:0], 1'b0};
        end
        // Multiply consumes the same top bit of amag, MSB first.
        c_next.prod = {cin.prod[2*DataWidth-2:0], 1'b0}
                    + (abit ? {{DataWidth{1'b0}}, cin.bmag} : '0);
        c_next.amag = {cin.amag[DataWidth-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cout <= '0;
        else
            cout <= c_next;
    end
endmodule
`default_nettype wire

@@ rtl/checked_signed_arithmetic_unit.sv @@
// Top level: operand front end, chain of division/multiply cells, result stage.
//
// Usage: drive func, first_operand and second_operand and pulse start; an
// item is taken at each rising edge with start high. busy is always low, so
// a new item may be issued every cycle.
// Each item passes through one input stage, DataWidth cells (one quotient bit
// and one multiplier bit per cell) and one output stage, which shows the result
// on value_out and status with done high. Throughput is one item per cycle.
// Add and subtract are resolved at the front and ride along.
// On error value_out is zero and status gives overflow or division by zero.
// Reset clears the valid bits of all stages; items in flight are dropped.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none
module checked_signed_arithmetic_unit
    import csau_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           func,
    input  wire logic signed [DataWidth-1:0] first_operand,
    input  wire logic signed [DataWidth-1:0] second_operand,
    output logic                      done,
    output logic signed [DataWidth-1:0] value_out,
    output logic [1:0]                status
);
    localparam logic [DataWidth-1:0] Limit = {1'b1, {(DataWidth-1){1'b0}}};

    cell_t  front_next;
    cell_t  chain [0:DataWidth];
    logic   na, nb;
    logic [DataWidth-1:0] sum, dif;

    logic                 done_reg;
    logic [DataWidth-1:0] value_reg, value_next;
    status_t              status_reg, status_next;

    assign busy = 1'b0;

    always_comb
    begin
        na  = first_operand[DataWidth-1];
        nb  = second_operand[DataWidth-1];
        sum = first_operand + second_operand;
        dif = first_operand - second_operand;
        front_next          = '0;
        front_next.vld      = start;
        front_next.func     = func_t'(func);
        front_next.neg      = na ^ nb;
        front_next.amag     = na ? (~first_operand + 1'b1) : first_operand;
        front_next.bmag     = nb ? (~second_operand + 1'b1) : second_operand;
        front_next.fast_st  = ST_OK;
        front_next.fast_val = '0;
        case (func_t'(func))
            FUNC_ADD:
            begin
                if (na == nb && sum[DataWidth-1] != na)
                    front_next.fast_st = ST_OVF;
                else
                    front_next.fast_val = sum;
            end
            FUNC_SUB:
            begin
                if (na != nb && dif[DataWidth-1] != na)
                    front_next.fast_st = ST_OVF;
                else
                    front_next.fast_val = dif;
            end
            FUNC_DIV:
            begin
                if (second_operand == '0)
                    front_next.fast_st = ST_DIV0;
                else if (first_operand == Limit && second_operand == '1)
                    front_next.fast_st = ST_OVF;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain[0] <= '0;
        else
            chain[0] <= front_next;
    end

    for (genvar i = 0; i < DataWidth; i++)
    begin : g_cell
        csau_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .cin  (chain[i]),
            .cout (chain[i+1])
        );
    end

    cell_t last;
    logic [DataWidth-1:0] ph, pl;
    assign last = chain[DataWidth];
    assign ph   = last.prod[2*DataWidth-1:DataWidth];
    assign pl   = last.prod[DataWidth-1:0];

    always_comb
    begin
        value_next  = last.fast_val;
        status_next = last.fast_st;
        case (last.func)
            FUNC_DIV:
            begin
                if (last.fast_st == ST_OK)
                    value_next = last.neg ? (~last.quo + 1'b1) : last.quo;
            end
            FUNC_MUL:
            begin
                if (ph != '0 || pl > (last.neg ? Limit : Limit - 1'b1))
                begin
                    status_next = ST_OVF;
                    value_next  = '0;
                end
                else
                    value_next = last.neg ? (~pl + 1'b1) : pl;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last.vld;
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign done      = done_reg;
    assign value_out = value_reg;
    assign status    = status_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> value_out == '0)
        else $error("error result with nonzero value");
    a_no_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != ST_RSVD)
        else $error("reserved status produced");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        last.vld |=> done)
        else $error("chain output lost");
endmodule
`default_nettype wire
